// ===== hdl/oad_pkg.sv =====
// oad_pkg: shared types, constants and the first-byte split for the oid arc decoder
// no dependencies; imported by every module of the block
package oad_pkg;

  // width of the arc field on the result channel
  localparam int ARC_W = 32;

  // first byte of an identifier packs two arcs as first * 40 + second
  localparam logic [7:0] FIRST_SPAN = 8'd40;
  // largest legal value of the first arc
  localparam logic [1:0] FIRST_MAX = 2'd2;

  // status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // one result item
  typedef struct packed {
    logic [ARC_W-1:0] arc;
    logic             status;
    logic             run_end;
    logic             oid_end;
  } result_t;

  // first byte split into quotient and remainder by 40
  typedef struct packed {
    logic       bad;
    logic [1:0] quot;
    logic [5:0] rem;
  } split_t;

  // a legal quotient is at most 2, so three compares replace the divider
  function automatic split_t split_first(logic [7:0] b);
    split_t s;
    logic [7:0] diff;
    s    = '0;
    diff = b;
    if (b < FIRST_SPAN) begin
      s.quot = 2'd0;
      diff   = b;
    end else if (b < 8'(2 * FIRST_SPAN)) begin
      s.quot = 2'd1;
      diff   = b - FIRST_SPAN;
    end else if (b < 8'(3 * FIRST_SPAN)) begin
      s.quot = FIRST_MAX;
      diff   = b - 8'(2 * FIRST_SPAN);
    end else begin
      s.bad  = 1'b1;
      s.quot = 2'd0;
      diff   = 8'd0;
    end
    s.rem = diff[5:0];
    return s;
  endfunction

endpackage

// ===== hdl/oad_decode.sv =====
// oad_decode: arc decode logic and decoder state (accumulator, first flag, skip flag, phase flag)
// depends on oad_pkg; fed by the input register of the top level
module oad_decode import oad_pkg::*; #(
  parameter int ARC_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       out_ready,
  output result_t    res,
  output logic       res_load,
  output logic       consume
);

  logic [ARC_BITS-1:0] acc;
  logic [ARC_BITS-1:0] acc_next;
  logic [ARC_BITS-1:0] acc_shift;
  logic [ARC_W-1:0]    acc_low;
  logic                expect_first;
  logic                expect_first_next;
  logic                skipping;
  logic                skipping_next;
  logic                phase;
  logic                phase_next;
  logic                emit;
  logic                done;
  split_t              split;

  // append seven payload bits, wrapping at ARC_BITS
  assign acc_shift = {acc[ARC_BITS-8:0], data_byte[6:0]};

  generate
    if (ARC_BITS >= ARC_W) begin : g_wide
      assign acc_low = acc_shift[ARC_W-1:0];
    end else begin : g_narrow
      assign acc_low = {{(ARC_W-ARC_BITS){1'b0}}, acc_shift};
    end
  endgenerate

  assign split = split_first(data_byte);

  // result and next state for the held item
  always_comb begin
    res               = '0;
    res.oid_end       = last_byte;
    emit              = 1'b0;
    done              = 1'b1;
    acc_next          = acc;
    expect_first_next = expect_first;
    skipping_next     = skipping;
    phase_next        = phase;
    if (expect_first) begin
      emit     = 1'b1;
      acc_next = '0;
      if (!phase) begin
        if (split.bad) begin
          res.status  = STATUS_BAD;
          res.run_end = 1'b1;
          if (!last_byte) begin
            skipping_next     = 1'b1;
            expect_first_next = 1'b0;
          end
        end else begin
          res.arc    = {{(ARC_W-2){1'b0}}, split.quot};
          done       = 1'b0;
          phase_next = 1'b1;
        end
      end else begin
        res.arc           = {{(ARC_W-6){1'b0}}, split.rem};
        res.run_end       = 1'b1;
        phase_next        = 1'b0;
        expect_first_next = last_byte;
      end
    end else if (skipping) begin
      if (last_byte) begin
        skipping_next     = 1'b0;
        expect_first_next = 1'b1;
        acc_next          = '0;
      end
    end else begin
      // continuation or closing byte of an arc
      emit        = !data_byte[7];
      res.arc     = acc_low;
      res.run_end = 1'b1;
      acc_next    = (emit || last_byte) ? '0 : acc_shift;
      if (last_byte) begin
        expect_first_next = 1'b1;
      end
    end
  end

  // an item moves on once its last result, if any, fits in the output register
  assign res_load = item_valid && emit && out_ready;
  assign consume  = item_valid && done && (!emit || out_ready);

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      expect_first <= 1'b1;
      skipping     <= 1'b0;
      phase        <= 1'b0;
    end else if (consume || res_load) begin
      acc          <= acc_next;
      expect_first <= expect_first_next;
      skipping     <= skipping_next;
      phase        <= phase_next;
    end
  end

endmodule

// ===== hdl/asn1_oid_arc_decoder_core.sv =====
// asn1_oid_arc_decoder_core: top level of the oid arc decoder
// depends on oad_pkg and oad_decode
//
// Usage: content bytes of BER object identifiers enter on the byte channel
// (byte_valid, byte_stall, data_byte, last_byte), with last_byte set on each
// identifier's final byte. Arcs leave on the result channel (res_valid,
// res_stall, arc, status, run_end, oid_end). A first byte gives two arcs
// (quotient and remainder by 40), or one error result with status 1 when it
// is 120 or more, after which the rest of that identifier gives nothing.
// Later bytes gather base-128 groups; an arc leaves on its closing byte.
// A byte is held in the input register and its first result is then loaded
// into the result register, which drives the result ports.
// Throughput: one byte per cycle while res_stall allows; a first byte holds
// the decoder while the single result register takes its two arcs in turn.
// Reset clears both channels and returns the decoder to expect a first byte.
// While res_stall is high the result holds; the input register keeps one
// byte and byte_stall rises once that byte cannot move on.
module asn1_oid_arc_decoder_core import oad_pkg::*; #(
  parameter int ARC_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_stall,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output logic             res_valid,
  input  logic             res_stall,
  output logic [ARC_W-1:0] arc,
  output logic             status,
  output logic             run_end,
  output logic             oid_end
);

  logic       in_full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_ready;
  logic       res_load;
  logic       consume;
  result_t    res_d;
  result_t    res_q;

  assign out_ready  = !res_valid || !res_stall;
  assign byte_stall = in_full && !consume;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      in_full <= 1'b1;
    end else if (consume) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_byte <= data_byte;
      in_last <= last_byte;
    end
  end

  oad_decode #(
    .ARC_BITS (ARC_BITS)
  ) u_decode (
    .clk        (clk),
    .rst        (rst),
    .item_valid (in_full),
    .data_byte  (in_byte),
    .last_byte  (in_last),
    .out_ready  (out_ready),
    .res        (res_d),
    .res_load   (res_load),
    .consume    (consume)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ready) begin
      res_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign arc     = res_q.arc;
  assign status  = res_q.status;
  assign run_end = res_q.run_end;
  assign oid_end = res_q.oid_end;

endmodule

// ===== hdl/oad_checker.sv =====
// oad_checker: port-level assertions for the oid arc decoder, bound to the top level
// depends on oad_pkg and asn1_oid_arc_decoder_core
module oad_checker import oad_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             res_valid,
  input logic             res_stall,
  input logic [ARC_W-1:0] arc,
  input logic             status,
  input logic             run_end,
  input logic             oid_end
);

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // an error result carries a zero arc
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == STATUS_BAD) |-> arc == '0)
    else $error("error result with nonzero arc");

  // an error is always the only result of its byte
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !run_end) |-> status == STATUS_OK)
    else $error("error result not ending its byte");

  // the second arc of a first byte follows at once
  a_pair: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && !run_end) |=>
      (res_valid && run_end && status == STATUS_OK && $stable(oid_end)))
    else $error("second first-byte arc missing");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(arc) && $stable(status)
      && $stable(run_end) && $stable(oid_end)))
    else $error("stalled result changed");

endmodule

bind asn1_oid_arc_decoder_core oad_checker u_oad_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .arc       (arc),
  .status    (status),
  .run_end   (run_end),
  .oid_end   (oid_end)
);

// ===== verif/tb.sv =====
// tb: self-checking testbench for asn1_oid_arc_decoder_core
// depends on oad_pkg and the decoder RTL; drives identifier bytes and checks every arc
module tb import oad_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 90;
  localparam int unsigned ITEMS_TOTAL = 1750;

  // first-byte shapes, unfinished arcs, overflow and skipping ({last_byte, data_byte})
  localparam logic [8:0] DIRECTED_BYTES [25] = '{
    9'h100, 9'h127, 9'h128, 9'h177, 9'h178,
    9'h0ff, 9'h07f, 9'h080, 9'h100,
    9'h050, 9'h081, 9'h000, 9'h1ff,
    9'h02a, 9'h08f, 9'h0ff, 9'h0ff, 9'h0ff, 9'h17f,
    9'h000, 9'h080, 9'h17f,
    9'h055, 9'h000, 9'h17f
  };

  // scoreboard: predicts the arcs of each accepted byte and checks them in order
  class oid_arc_scoreboard;
    logic [ARC_W-1:0] arc_sum;
    bit               at_first;
    bit               dropping;
    result_t          arcs_due[$];
    int unsigned      errors;

    function new();
      arc_sum  = '0;
      at_first = 1'b1;
      dropping = 1'b0;
      errors   = 0;
    endfunction

    function void push_arc(logic [ARC_W-1:0] value, logic stat, logic run_last,
                           logic oid_last);
      result_t r;
      r.arc     = value;
      r.status  = stat;
      r.run_end = run_last;
      r.oid_end = oid_last;
      arcs_due.push_back(r);
    endfunction

    // returns 0 when the byte belongs to an abandoned identifier
    function bit note_byte(logic [7:0] b, logic last);
      if (at_first) begin
        arc_sum = '0;
        if (b >= 8'(3 * FIRST_SPAN)) begin
          push_arc('0, STATUS_BAD, 1'b1, last);
          if (!last) begin
            dropping = 1'b1;
            at_first = 1'b0;
          end
        end else begin
          push_arc(ARC_W'(b / FIRST_SPAN), STATUS_OK, 1'b0, last);
          push_arc(ARC_W'(b % FIRST_SPAN), STATUS_OK, 1'b1, last);
          at_first = last;
        end
        return 1'b1;
      end
      if (dropping) begin
        if (last) begin
          dropping = 1'b0;
          at_first = 1'b1;
          arc_sum  = '0;
        end
        return 1'b0;
      end
      // base-128 group, wraps at the arc width
      arc_sum = {arc_sum[ARC_W-8:0], b[6:0]};
      if (!b[7]) begin
        push_arc(arc_sum, STATUS_OK, 1'b1, last);
        arc_sum = '0;
      end
      if (last) begin
        arc_sum  = '0;
        at_first = 1'b1;
      end
      return 1'b1;
    endfunction

    function void check_arc(result_t got);
      result_t want;
      if (arcs_due.size() == 0) begin
        $error("unexpected result: arc %0h status %0b run_end %0b oid_end %0b",
               got.arc, got.status, got.run_end, got.oid_end);
        errors++;
        return;
      end
      want = arcs_due.pop_front();
      if (got.arc !== want.arc) begin
        $error("arc: expected %0h, got %0h", want.arc, got.arc);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0b, got %0b", want.status, got.status);
        errors++;
      end
      if (got.run_end !== want.run_end) begin
        $error("run_end: expected %0b, got %0b", want.run_end, got.run_end);
        errors++;
      end
      if (got.oid_end !== want.oid_end) begin
        $error("oid_end: expected %0b, got %0b", want.oid_end, got.oid_end);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return arcs_due.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             byte_valid = 1'b0;
  logic             byte_stall;
  logic [7:0]       data_byte = 8'h00;
  logic             last_byte = 1'b0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  logic [ARC_W-1:0] arc;
  logic             status;
  logic             run_end;
  logic             oid_end;

  oid_arc_scoreboard sb;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       bytes_sent = 0;
  int unsigned       hold_left = 0;
  bit                hold_request = 1'b0;
  int unsigned       cycle_count = 0;

  asn1_oid_arc_decoder_core DUT (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .arc        (arc),
    .status     (status),
    .run_end    (run_end),
    .oid_end    (oid_end)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: take accepted arcs, then pick the stall for the next cycle
  always @(posedge clk) begin
    result_t seen;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        seen.arc     = arc;
        seen.status  = status;
        seen.run_end = run_end;
        seen.oid_end = oid_end;
        sb.check_arc(seen);
      end
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // offer one byte, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= last;
    do @(posedge clk); while (byte_stall);
    if (sb.note_byte(b, last))
      bytes_sent++;
  endtask

  // one arc of the given number of base-128 groups with random content
  task automatic send_arc(input int unsigned groups, input logic closes_oid);
    logic [7:0] b;
    for (int unsigned g = 1; g <= groups; g++) begin
      b    = 8'($urandom);
      b[7] = (g != groups);
      send_byte(b, (g == groups) && closes_oid);
    end
  endtask

  // mostly well-formed identifiers, some malformed, unfinished or plain noise
  task automatic send_random_oid();
    int unsigned pick;
    int unsigned narcs;
    int unsigned nfill;
    int unsigned groups;
    logic        trailing;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // bad first byte, rest of the identifier is skipped
      nfill = $urandom_range(4);
      send_byte(8'($urandom_range(255, 120)), nfill == 0);
      for (int unsigned i = 1; i <= nfill; i++)
        send_byte(8'($urandom), i == nfill);
    end else if (pick < 14) begin
      // noise, closed by a last byte so framing comes back
      nfill = $urandom_range(6, 1);
      for (int unsigned i = 1; i <= nfill; i++)
        send_byte(8'($urandom), (i == nfill) || ($urandom_range(7) == 0));
    end else begin
      trailing = (pick < 22);
      narcs    = $urandom_range(5);
      send_byte(8'($urandom_range(119)), (narcs == 0) && !trailing);
      for (int unsigned i = 1; i <= narcs; i++) begin
        // long arcs overflow the accumulator
        groups = ($urandom_range(9) == 0) ? $urandom_range(7, 5) : $urandom_range(3, 1);
        send_arc(groups, (i == narcs) && !trailing);
      end
      if (trailing) begin
        nfill = $urandom_range(3, 1);
        for (int unsigned i = 1; i <= nfill; i++)
          send_byte({1'b1, 7'($urandom)}, i == nfill);
      end
    end
  endtask

  // stop offering until every predicted arc has come out
  task automatic wait_drained();
    byte_valid <= 1'b0;
    while (sb.pending() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // stimulus and end of run
  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 34;
    recv_idle_pct = 58;
    foreach (DIRECTED_BYTES[i])
      send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
    while (bytes_sent < ITEMS_TOTAL / 3)
      send_random_oid();
    wait_drained();

    send_idle_pct = 58;
    recv_idle_pct = 34;
    while (bytes_sent < 2 * ITEMS_TOTAL / 3)
      send_random_oid();
    wait_drained();

    // long receiver hold while bytes keep coming, then free running
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    while (bytes_sent < ITEMS_TOTAL)
      send_random_oid();
    wait_drained();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
